/* rtl/core/rgb2yuyv_pkg.sv */
// ---------------------------------------------------------------------------
// rgb2yuyv_pkg
// Shared types and constants for the RGB pair to YUYV converter: component
// weights in thousandths, the reciprocal used for the divide by 1000, and the
// sign/magnitude term that passes between the arithmetic stages.
// ---------------------------------------------------------------------------
`default_nettype none

package rgb2yuyv_pkg;

	localparam int unsigned PIX_W  = 8;
	// Signed width of a weighted sum; |sum| stays at or below 255000.
	localparam int unsigned SUM_W  = 20;
	localparam int unsigned MAG_W  = 18;
	// floor(m / 1000) == (m * DIV_RECIP) >> DIV_SHIFT for every m below 2**MAG_W,
	// since m * (DIV_RECIP * 1000 - 2**DIV_SHIFT) stays below 2**DIV_SHIFT.
	localparam int unsigned DIV_SHIFT = 28;
	localparam int unsigned RECIP_W   = 19;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 19'd268436;
	localparam logic [PIX_W-1:0]   CHROMA_OFFSET = 8'd128;

	typedef struct packed {
		logic signed [SUM_W-1:0] kr;
		logic signed [SUM_W-1:0] kg;
		logic signed [SUM_W-1:0] kb;
	} coef_t;

	localparam coef_t COEF_Y = '{kr: 20'sd299,  kg: 20'sd587,  kb: 20'sd114};
	localparam coef_t COEF_U = '{kr: -20'sd169, kg: -20'sd331, kb: 20'sd500};
	localparam coef_t COEF_V = '{kr: 20'sd500,  kg: -20'sd419, kb: -20'sd81};

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} term_t;

	typedef struct packed {
		logic             neg;
		logic [PIX_W-1:0] quo;
	} quot_t;

endpackage

`default_nettype wire

/* rtl/core/rgb2yuyv_mac.sv */
// ---------------------------------------------------------------------------
// rgb2yuyv_mac
// Weighted sum of one pixel's three components, returned as sign and
// magnitude so that the divide truncates toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module rgb2yuyv_mac (
	input  wire logic [rgb2yuyv_pkg::PIX_W-1:0] red,
	input  wire logic [rgb2yuyv_pkg::PIX_W-1:0] green,
	input  wire logic [rgb2yuyv_pkg::PIX_W-1:0] blue,
	input  wire rgb2yuyv_pkg::coef_t             coef,
	output rgb2yuyv_pkg::term_t                  term
);
	import rgb2yuyv_pkg::*;

	logic signed [SUM_W-1:0] r_ext;
	logic signed [SUM_W-1:0] g_ext;
	logic signed [SUM_W-1:0] b_ext;
	logic signed [SUM_W-1:0] sum;
	logic        [SUM_W-1:0] abs_sum;

	assign r_ext = $signed({{(SUM_W-PIX_W){1'b0}}, red});
	assign g_ext = $signed({{(SUM_W-PIX_W){1'b0}}, green});
	assign b_ext = $signed({{(SUM_W-PIX_W){1'b0}}, blue});

	assign sum     = coef.kr * r_ext + coef.kg * g_ext + coef.kb * b_ext;
	assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

	assign term.neg = sum[SUM_W-1];
	assign term.mag = abs_sum[MAG_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/rgb2yuyv_div.sv */
// ---------------------------------------------------------------------------
// rgb2yuyv_div
// Divides a magnitude by 1000 through a reciprocal multiply; exact over the
// whole magnitude range, so no correction step is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module rgb2yuyv_div (
	input  wire rgb2yuyv_pkg::term_t term,
	output rgb2yuyv_pkg::quot_t      quot
);
	import rgb2yuyv_pkg::*;

	localparam int unsigned PROD_W = MAG_W + RECIP_W;

	logic [PROD_W-1:0] prod;

	assign prod = {{RECIP_W{1'b0}}, term.mag} * {{MAG_W{1'b0}}, DIV_RECIP};

	assign quot.neg = term.neg;
	assign quot.quo = prod[DIV_SHIFT+PIX_W-1:DIV_SHIFT];

endmodule

`default_nettype wire

/* rtl/core/rgb_pair_to_yuyv_unit.sv */
// ---------------------------------------------------------------------------
// rgb_pair_to_yuyv_unit
// Converts a pair of RGB24 pixels into one YUYV 4:2:2 group. The unit takes
// one pixel pair per cycle and delivers one group per cycle while the output
// is not stalled; a pair taken into the input register passes a weighted sum
// register, a quotient register and the result register in turn. Luma
// comes from each pixel, both chroma bytes from the first pixel only. Each sum
// is divided by 1000 truncating toward zero, chroma gets 128 added, and every
// byte is clamped to 0..255. Every stage holds while the next one is full and
// stalled, so the input keeps taking pairs until the whole pipeline is occupied.
// ---------------------------------------------------------------------------
`default_nettype none

module rgb_pair_to_yuyv_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [rgb2yuyv_pkg::PIX_W-1:0]   red_first,
	input  wire logic [rgb2yuyv_pkg::PIX_W-1:0]   green_first,
	input  wire logic [rgb2yuyv_pkg::PIX_W-1:0]   blue_first,
	input  wire logic [rgb2yuyv_pkg::PIX_W-1:0]   red_second,
	input  wire logic [rgb2yuyv_pkg::PIX_W-1:0]   green_second,
	input  wire logic [rgb2yuyv_pkg::PIX_W-1:0]   blue_second,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [rgb2yuyv_pkg::PIX_W-1:0]        luma_first,
	output logic [rgb2yuyv_pkg::PIX_W-1:0]        chroma_blue,
	output logic [rgb2yuyv_pkg::PIX_W-1:0]        luma_second,
	output logic [rgb2yuyv_pkg::PIX_W-1:0]        chroma_red
);
	import rgb2yuyv_pkg::*;

	function automatic logic [PIX_W-1:0] fin_byte(input logic neg,
			input logic [PIX_W-1:0] quo, input logic [PIX_W-1:0] offs);
		logic signed [PIX_W+1:0] v;
		logic [PIX_W-1:0] res;
		v = $signed({2'b00, quo});
		if (neg) begin
			v = -v;
		end
		v = v + $signed({2'b00, offs});
		if (v < 0) begin
			res = '0;
		end else if (v > $signed({2'b00, {PIX_W{1'b1}}})) begin
			res = '1;
		end else begin
			res = v[PIX_W-1:0];
		end
		return res;
	endfunction

	// Stage 1: input register.
	logic vld_s1, vld_s2, vld_s3, out_valid_q;
	logic [PIX_W-1:0] r1_s1, g1_s1, b1_s1, r2_s1, g2_s1, b2_s1;
	term_t y1_s2, u_s2, y2_s2, v_s2;
	quot_t y1_s3, u_s3, y2_s3, v_s3;
	logic [PIX_W-1:0] luma_first_q, chroma_blue_q, luma_second_q, chroma_red_q;

	term_t y1_t, u_t, y2_t, v_t;
	quot_t y1_d, u_d, y2_d, v_d;

	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;

	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy_s3  = !vld_s3 || rdy_out;
	assign rdy_s2  = !vld_s2 || rdy_s3;
	assign rdy_s1  = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	rgb2yuyv_mac u_mac_y1 (.red(r1_s1), .green(g1_s1), .blue(b1_s1),
		.coef(COEF_Y), .term(y1_t));
	rgb2yuyv_mac u_mac_u  (.red(r1_s1), .green(g1_s1), .blue(b1_s1),
		.coef(COEF_U), .term(u_t));
	rgb2yuyv_mac u_mac_y2 (.red(r2_s1), .green(g2_s1), .blue(b2_s1),
		.coef(COEF_Y), .term(y2_t));
	rgb2yuyv_mac u_mac_v  (.red(r1_s1), .green(g1_s1), .blue(b1_s1),
		.coef(COEF_V), .term(v_t));

	rgb2yuyv_div u_div_y1 (.term(y1_s2), .quot(y1_d));
	rgb2yuyv_div u_div_u  (.term(u_s2),  .quot(u_d));
	rgb2yuyv_div u_div_y2 (.term(y2_s2), .quot(y2_d));
	rgb2yuyv_div u_div_v  (.term(v_s2),  .quot(v_d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_out) begin
				out_valid_q <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			r1_s1 <= red_first;
			g1_s1 <= green_first;
			b1_s1 <= blue_first;
			r2_s1 <= red_second;
			g2_s1 <= green_second;
			b2_s1 <= blue_second;
		end
		if (rdy_s2 && vld_s1) begin
			y1_s2 <= y1_t;
			u_s2  <= u_t;
			y2_s2 <= y2_t;
			v_s2  <= v_t;
		end
		if (rdy_s3 && vld_s2) begin
			y1_s3 <= y1_d;
			u_s3  <= u_d;
			y2_s3 <= y2_d;
			v_s3  <= v_d;
		end
		if (rdy_out && vld_s3) begin
			luma_first_q  <= fin_byte(y1_s3.neg, y1_s3.quo, '0);
			chroma_blue_q <= fin_byte(u_s3.neg,  u_s3.quo,  CHROMA_OFFSET);
			luma_second_q <= fin_byte(y2_s3.neg, y2_s3.quo, '0);
			chroma_red_q  <= fin_byte(v_s3.neg,  v_s3.quo,  CHROMA_OFFSET);
		end
	end

	assign out_valid   = out_valid_q;
	assign luma_first  = luma_first_q;
	assign chroma_blue = chroma_blue_q;
	assign luma_second = luma_second_q;
	assign chroma_red  = chroma_red_q;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_pair_to_yuyv_unit. A driver feeds pixel pairs
// from a queue, a predictor computes the YUYV group each accepted word should
// give, and a monitor compares every delivered group with the predicted one. Both
// sides idle in short random bursts, and one long output hold fills the pipe.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import rgb2yuyv_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PAIRS   = 1200;
	localparam int QUIET_TAIL     = 150;
	localparam int LONG_HOLD      = 60;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [PIX_W-1:0] red_first;
		logic [PIX_W-1:0] green_first;
		logic [PIX_W-1:0] blue_first;
		logic [PIX_W-1:0] red_second;
		logic [PIX_W-1:0] green_second;
		logic [PIX_W-1:0] blue_second;
	} pixel_pair_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma_first;
		logic [PIX_W-1:0] chroma_blue;
		logic [PIX_W-1:0] luma_second;
		logic [PIX_W-1:0] chroma_red;
	} yuyv_group_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_W-1:0] red_first = '0;
	logic [PIX_W-1:0] green_first = '0;
	logic [PIX_W-1:0] blue_first = '0;
	logic [PIX_W-1:0] red_second = '0;
	logic [PIX_W-1:0] green_second = '0;
	logic [PIX_W-1:0] blue_second = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] luma_first;
	logic [PIX_W-1:0] chroma_blue;
	logic [PIX_W-1:0] luma_second;
	logic [PIX_W-1:0] chroma_red;

	pixel_pair_t pending_pairs[$];
	yuyv_group_t expected_groups[$];
	pixel_pair_t driven_pair = '0;
	pixel_pair_t next_pair;
	yuyv_group_t want_group;
	yuyv_group_t got_group;

	int pairs_taken = 0;
	int groups_checked = 0;
	int mismatches = 0;
	int send_idle_left = 0;
	int recv_idle_left = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	bit fill_done = 1'b0;
	bit quiet;
	int idle_cycles = 0;

	// Idling stops once the tail of the random stream is reached.
	assign quiet = fill_done && (pending_pairs.size() < QUIET_TAIL);

	rgb_pair_to_yuyv_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.red_first    (red_first),
		.green_first  (green_first),
		.blue_first   (blue_first),
		.red_second   (red_second),
		.green_second (green_second),
		.blue_second  (blue_second),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.luma_first   (luma_first),
		.chroma_blue  (chroma_blue),
		.luma_second  (luma_second),
		.chroma_red   (chroma_red)
	);

	function automatic logic [PIX_W-1:0] clamp_byte(int v);
		if (v < 0)
			return '0;
		if (v > 255)
			return 8'd255;
		return v[PIX_W-1:0];
	endfunction

	// SystemVerilog integer division truncates toward zero, as the block must.
	function automatic yuyv_group_t predict_yuyv(pixel_pair_t p);
		int r1, g1, b1, r2, g2, b2;
		yuyv_group_t g;
		r1 = int'(p.red_first);
		g1 = int'(p.green_first);
		b1 = int'(p.blue_first);
		r2 = int'(p.red_second);
		g2 = int'(p.green_second);
		b2 = int'(p.blue_second);
		g.luma_first  = clamp_byte((299 * r1 + 587 * g1 + 114 * b1) / 1000);
		g.chroma_blue = clamp_byte((-169 * r1 - 331 * g1 + 500 * b1) / 1000 + 128);
		g.luma_second = clamp_byte((299 * r2 + 587 * g2 + 114 * b2) / 1000);
		g.chroma_red  = clamp_byte((500 * r1 - 419 * g1 - 81 * b1) / 1000 + 128);
		return g;
	endfunction

	// Uniform a third of the time, otherwise at or near the ends of the range.
	function automatic logic [PIX_W-1:0] random_component();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 8'd255;
			2: return 8'($urandom_range(0, 7));
			3: return 8'($urandom_range(248, 255));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_pair(input int r1, input int g1, input int b1,
			input int r2, input int g2, input int b2);
		pixel_pair_t p;
		p.red_first    = 8'(r1);
		p.green_first  = 8'(g1);
		p.blue_first   = 8'(b1);
		p.red_second   = 8'(r2);
		p.green_second = 8'(g2);
		p.blue_second  = 8'(b2);
		pending_pairs.push_back(p);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// Driver: a word that is offered stays on the bus until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_groups.push_back(predict_yuyv(driven_pair));
				pairs_taken <= pairs_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (send_idle_left > 0) begin
					send_idle_left <= send_idle_left - 1;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					send_idle_left <= $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					next_pair = pending_pairs.pop_front();
					driven_pair <= next_pair;
					red_first <= next_pair.red_first;
					green_first <= next_pair.green_first;
					blue_first <= next_pair.blue_first;
					red_second <= next_pair.red_second;
					green_second <= next_pair.green_second;
					blue_second <= next_pair.blue_second;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each delivered group and drives the output stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid === 1'b1 && !out_stall) begin
				got_group = '{luma_first, chroma_blue, luma_second, chroma_red};
				groups_checked <= groups_checked + 1;
				if (expected_groups.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < MAX_REPORTS)
						$display("ERROR: unexpected group y0=%0d u=%0d y1=%0d v=%0d",
							got_group.luma_first, got_group.chroma_blue,
							got_group.luma_second, got_group.chroma_red);
				end else begin
					want_group = expected_groups.pop_front();
					if (got_group !== want_group) begin
						mismatches <= mismatches + 1;
						if (mismatches < MAX_REPORTS)
							$display("ERROR: group %0d expected y0=%0d u=%0d y1=%0d v=%0d, got y0=%0d u=%0d y1=%0d v=%0d",
								groups_checked, want_group.luma_first,
								want_group.chroma_blue, want_group.luma_second,
								want_group.chroma_red, got_group.luma_first,
								got_group.chroma_blue, got_group.luma_second,
								got_group.chroma_red);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!long_hold_done && pairs_taken >= 100) begin
				// A long hold lets the pipeline fill so the input has to stall.
				hold_left <= LONG_HOLD - 1;
				long_hold_done <= 1'b1;
				out_stall <= 1'b1;
			end else if (recv_idle_left > 0) begin
				recv_idle_left <= recv_idle_left - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_idle_left <= $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d groups outstanding",
					expected_groups.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_pair(0, 0, 0, 0, 0, 0);
		queue_pair(255, 255, 255, 255, 255, 255);
		queue_pair(0, 0, 0, 255, 255, 255);
		queue_pair(255, 255, 255, 0, 0, 0);
		queue_pair(255, 0, 0, 0, 255, 0);
		queue_pair(0, 255, 0, 0, 0, 255);
		queue_pair(0, 0, 255, 255, 0, 0);
		queue_pair(255, 255, 0, 0, 255, 255);
		queue_pair(0, 255, 255, 255, 0, 255);
		queue_pair(255, 0, 255, 255, 255, 0);
		queue_pair(128, 128, 128, 127, 127, 127);
		queue_pair(1, 1, 1, 254, 254, 254);
		// The second pixel's color must not move the chroma bytes.
		queue_pair(200, 40, 90, 0, 0, 255);
		queue_pair(200, 40, 90, 255, 0, 0);
		queue_pair(200, 40, 90, 0, 255, 0);
		// Small negative chroma sums where truncation and flooring differ.
		queue_pair(3, 0, 0, 0, 0, 0);
		queue_pair(0, 3, 0, 0, 0, 0);
		queue_pair(0, 4, 0, 0, 0, 0);
		queue_pair(0, 0, 3, 0, 0, 0);
		queue_pair(1, 2, 0, 3, 0, 1);

		// Sender pause: let every group of the directed words come back.
		do
			@(negedge clk);
		while (pending_pairs.size() != 0 || in_valid || expected_groups.size() != 0);

		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			next_pair.red_first    = random_component();
			next_pair.green_first  = random_component();
			next_pair.blue_first   = random_component();
			next_pair.red_second   = random_component();
			next_pair.green_second = random_component();
			next_pair.blue_second  = random_component();
			pending_pairs.push_back(next_pair);
		end
		fill_done = 1'b1;

		do
			@(negedge clk);
		while (pending_pairs.size() != 0 || in_valid || expected_groups.size() != 0);
		repeat (20) @(negedge clk);

		$display("Converted %0d pixel pairs and checked %0d YUYV groups,", pairs_taken,
			groups_checked);
		$display("covering range extremes, chroma truncation and a full-pipeline hold.");
		if (mismatches == 0 && expected_groups.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
